// ----- rtl/core/uer_pkg.sv -----
// Package: shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps
package uer_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int DIST_W      = 12;
  localparam int TIME_W      = 16;
  localparam int STOP_W      = 17;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 2'd3;

  localparam logic [7:0]  TRIGGER_TICKS_RST  = 8'd30;
  localparam logic [15:0] WAIT_LIMIT_RST     = 16'd10000;
  localparam logic [15:0] WIDTH_LIMIT_RST    = 16'd23530;
  localparam logic [7:0]  OVERFLOW_LIMIT_RST = 8'd100;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // cm = 340*t/10000 = 17*t/500; divide by 500 as multiply by ceil(2^30/500).
  localparam int          PROD_W      = 21;
  localparam int          RECIP_SHIFT = 30;
  localparam int          RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP_500 = 22'd2147484;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] wait_limit;
    logic [15:0] width_limit;
    logic [7:0]  overflow_limit;
  } uer_cfg_t;

  // Stage-one result: flags plus clamped echo time of the last measurement.
  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic              timed_out;
    logic [TIME_W-1:0] echo_time;
  } uer_res_t;

endpackage

// ----- rtl/core/uer_if.sv -----
// Channel interfaces: tick input and result output.
`timescale 1ns / 1ps
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;
  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_out_if;
  logic                      valid;
  logic                      ready;
  logic                      trigger;
  logic                      busy_res;
  logic                      done_res;
  logic                      timed_out;
  logic [uer_pkg::DIST_W-1:0] distance_cm;
  modport source (output valid, output trigger, output busy_res, output done_res,
                  output timed_out, output distance_cm, input ready);
  modport sink   (input valid, input trigger, input busy_res, input done_res,
                  input timed_out, input distance_cm, output ready);
endinterface

// ----- rtl/core/ultrasonic_echo_ranger_core.sv -----
// Top level: ultrasonic echo-pulse ranger with config registers and output stage.
`timescale 1ns / 1ps
// Usage
//   in_ch carries one 0.5 us timer tick per transfer (start_req, echo level).
//   out_ch returns exactly one result per tick: trigger drive, busy, done,
//   timed_out (only with done) and the last measured distance in cm.
//   cfg_we/cfg_idx/cfg_wdata write trigger_ticks, wait_limit, width_limit
//   and overflow_limit; write them only while no measurement is running.
// Timing
//   An input transfer reaches result valid through two registered stages:
//   the phase machine and counters, then the ticks-to-cm multiply.
//   Throughput is one tick per cycle while out_ch is not stalled.
// Reset
//   rst_n (synchronous) returns to idle, clears counters and the stored echo time,
//   and loads the default limits. No result is pending after reset.
// Backpressure
//   When out_ch is stalled the whole two-stage pipe holds and in_ch.ready
//   drops; it rises again in the cycle the waiting result is taken.
module ultrasonic_echo_ranger_core (
  input  logic                           clk,
  input  logic                           rst_n,
  uer_in_if.sink                         in_ch,
  uer_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [uer_pkg::CFG_W-1:0]      cfg_wdata
);
  import uer_pkg::*;

  uer_cfg_t cfg_r;
  logic     en;
  logic     in_fire;
  logic     s1_vld;
  uer_res_t s1;

  logic                      out_vld_r;
  logic                      trigger_r, busy_r, done_r, tout_r;
  logic [DIST_W-1:0]         dist_r, dist_nxt;
  logic [PROD_W-1:0]         x17;
  logic [PROD_W+RECIP_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks  <= TRIGGER_TICKS_RST;
      cfg_r.wait_limit     <= WAIT_LIMIT_RST;
      cfg_r.width_limit    <= WIDTH_LIMIT_RST;
      cfg_r.overflow_limit <= OVERFLOW_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TRIGGER_TICKS:  cfg_r.trigger_ticks  <= cfg_wdata[7:0];
        REG_WAIT_LIMIT:     cfg_r.wait_limit     <= cfg_wdata;
        REG_WIDTH_LIMIT:    cfg_r.width_limit    <= cfg_wdata;
        REG_OVERFLOW_LIMIT: cfg_r.overflow_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipe advances whenever the output slot is free or being taken.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  uer_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_fire   (in_fire),
    .start_req (in_ch.start_req),
    .echo      (in_ch.echo),
    .cfg       (cfg_r),
    .s1_vld    (s1_vld),
    .s1        (s1)
  );

  // 17*t then /500 by reciprocal; exact for 17*t < 2^21.
  assign x17      = {1'b0, s1.echo_time, 4'd0} + PROD_W'(s1.echo_time);
  assign prod     = (PROD_W+RECIP_W)'(x17) * (PROD_W+RECIP_W)'(RECIP_500);
  assign dist_nxt = prod[RECIP_SHIFT +: DIST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_vld) begin
      trigger_r <= s1.trigger;
      busy_r    <= s1.busy;
      done_r    <= s1.done;
      tout_r    <= s1.timed_out;
      dist_r    <= dist_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.trigger     = trigger_r;
  assign out_ch.busy_res    = busy_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.timed_out   = tout_r;
  assign out_ch.distance_cm = dist_r;

endmodule

// ----- rtl/core/uer_seq.sv -----
// Measurement sequencer: phase machine, tick counters and stage-one register.
`timescale 1ns / 1ps
module uer_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_fire,
  input  logic              start_req,
  input  logic              echo,
  input  uer_pkg::uer_cfg_t cfg,
  output logic              s1_vld,
  output uer_pkg::uer_res_t s1
);
  import uer_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [7:0]             trig_cnt_r, trig_cnt_nxt;
  logic [TIME_W-1:0]      last_t_r, last_t_nxt;
  logic                   s1_vld_r;
  uer_res_t               s1_r, s1_nxt;

  logic [7:0]             len;
  logic [7:0]             trig_inc;
  logic [COUNT_WIDTH-1:0] tick_bump;
  logic [COUNT_WIDTH-1:0] tick_q;
  logic [STOP_W-1:0]      stop;
  logic [8:0]             ovf_p1;
  logic                   meas_end;
  logic                   trig_o, done_o, tout_o;

  assign len       = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
  assign trig_inc  = trig_cnt_r + 8'd1;
  assign tick_bump = (tick_r == CNT_MAX) ? tick_r : tick_r + COUNT_WIDTH'(1);
  assign tick_q    = tick_bump >> 2;
  assign ovf_p1    = {1'b0, cfg.overflow_limit} + 9'd1;
  assign stop      = {ovf_p1, 8'd0};

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    trig_cnt_nxt = trig_cnt_r;
    last_t_nxt   = last_t_r;
    trig_o       = 1'b0;
    done_o       = 1'b0;
    tout_o       = 1'b0;
    meas_end     = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          trig_o       = 1'b1;
          trig_cnt_nxt = 8'd1;
          tick_nxt     = '0;
          phase_nxt    = (len == 8'd1) ? PH_WAIT : PH_TRIG;
        end
      end
      PH_TRIG: begin
        trig_o       = 1'b1;
        trig_cnt_nxt = trig_inc;
        if (trig_inc >= len || trig_inc == 8'd0) begin
          phase_nxt = PH_WAIT;
          tick_nxt  = '0;
        end
      end
      PH_WAIT: begin
        tick_nxt = tick_bump;
        if (tick_q > COUNT_WIDTH'(cfg.wait_limit) || tick_bump == CNT_MAX) begin
          done_o    = 1'b1;
          tout_o    = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (echo) begin
          tick_nxt  = COUNT_WIDTH'(1);
          phase_nxt = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (!echo) begin
          meas_end = 1'b1;
        end else begin
          tick_nxt = tick_bump;
          if (33'(tick_bump) >= 33'(stop) || tick_bump == CNT_MAX) begin
            meas_end = 1'b1;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
    if (meas_end) begin
      // Clamp ticks/4 to the width limit; conversion to cm happens downstream.
      if ((tick_nxt >> 2) > COUNT_WIDTH'(cfg.width_limit)) begin
        last_t_nxt = cfg.width_limit;
      end else begin
        last_t_nxt = tick_nxt[TIME_W+1:2];
      end
      done_o    = 1'b1;
      phase_nxt = PH_IDLE;
    end
    s1_nxt.trigger   = trig_o;
    s1_nxt.busy      = (phase_nxt != PH_IDLE);
    s1_nxt.done      = done_o;
    s1_nxt.timed_out = tout_o;
    s1_nxt.echo_time = last_t_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      trig_cnt_r <= '0;
      last_t_r   <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      if (en) begin
        s1_vld_r <= in_fire;
      end
      if (in_fire) begin
        phase_r    <= phase_nxt;
        tick_r     <= tick_nxt;
        trig_cnt_r <= trig_cnt_nxt;
        last_t_r   <= last_t_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_vld = s1_vld_r;
  assign s1     = s1_r;

endmodule

// ----- rtl/core/uer_check.sv -----
// Port-level checker for the echo ranger, bound to the top level.
`timescale 1ns / 1ps
module uer_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        trigger,
  input logic                        busy_res,
  input logic                        done_res,
  input logic                        timed_out,
  input logic [uer_pkg::DIST_W-1:0]  distance_cm
);

  a_tout_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && timed_out |-> done_res)
    else $error("timed_out without done_res");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("busy_res set on the tick a measurement ends");

  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && trigger |-> busy_res)
    else $error("trigger driven while not busy");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm) && $stable(done_res))
    else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger_core uer_check u_uer_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .trigger     (out_ch.trigger),
  .busy_res    (out_ch.busy_res),
  .done_res    (out_ch.done_res),
  .timed_out   (out_ch.timed_out),
  .distance_cm (out_ch.distance_cm)
);
